@@ src/skf_pkg.sv @@
// Shared types and constants for the three-channel scalar Kalman filter.
`timescale 1ns / 1ps

package skf_pkg;

    // Default fixed-point format
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int FIELD_W   = 32;
    localparam int REG_W     = 21;
    localparam int CFG_IDX_W = 3;
    localparam int NCHAN     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_SHIFT_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_SHIFT_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_ANGLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R_SHIFT_Y = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DEN,
        ST_DIV,
        ST_MUL,
        ST_EST,
        ST_COV,
        ST_DONE
    } skf_state_t;

endpackage

@@ src/skf_div.sv @@
// Restoring shift-subtract divider producing the Kalman gain, one quotient bit per cycle.
`timescale 1ns / 1ps

module skf_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 33,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CntW = $clog2(Q_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    // One compare/subtract step; quotient weight starts at 2^(Q_W-1)
    always_comb
    begin
        trial     = rem_reg - {1'b0, den_reg};
        ge        = (rem_reg >= {1'b0, den_reg});
        rem_next  = ge ? {trial[DEN_W-1:0], 1'b0} : {rem_reg[DEN_W-1:0], 1'b0};
        quot_next = {quot_reg[Q_W-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the last step
            done_reg <= busy_reg && !start && (cnt_reg == CntW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= (DEN_W + 1)'(num);
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ src/scalar_kalman_three_channel.sv @@
// Top level: three scalar random-walk Kalman filters sharing one divider and one multiplier.
`timescale 1ns / 1ps

// Three independent scalar Kalman filters (angle, x shift, y shift) in Q16.16 by
// default. Each input transfer carries a prior and a measurement per channel; the
// block updates est = prior + g*(meas - prior) with g = p'/(p'+r), p' = p + q, and keeps
// p = (1 - g)*p' per channel (reset 1.0). Channels run one after another through a
// single restoring divider (FRAC_BITS+1 steps) and one shared multiplier. For each
// channel the sequencer steps through PRED, DEN, DIV, MUL, EST and COV; after the last
// channel it enters DONE, loads the output register and returns to IDLE, where the next
// item can be taken. A channel whose denominator is zero skips the divider (gain 0).
// A new item is taken as soon as the previous one is finished, even while its
// result still waits in the output register; an item whose result is ready while
// the previous one is still unaccepted waits for it.
// Configuration registers (q: indexes 0-2, r: indexes 3-5) are written with cfg_we and
// must only change while the block is idle; unknown indexes are ignored.

module scalar_kalman_three_channel #(
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skf_pkg::REG_W-1:0]           cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [skf_pkg::FIELD_W-1:0]  prior_angle,
    input  logic signed [skf_pkg::FIELD_W-1:0]  prior_shift_x,
    input  logic signed [skf_pkg::FIELD_W-1:0]  prior_shift_y,
    input  logic signed [skf_pkg::FIELD_W-1:0]  meas_angle,
    input  logic signed [skf_pkg::FIELD_W-1:0]  meas_shift_x,
    input  logic signed [skf_pkg::FIELD_W-1:0]  meas_shift_y,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [skf_pkg::FIELD_W-1:0]  est_angle,
    output logic signed [skf_pkg::FIELD_W-1:0]  est_shift_x,
    output logic signed [skf_pkg::FIELD_W-1:0]  est_shift_y
);

    localparam int FieldW = skf_pkg::FIELD_W;
    localparam int NChan  = skf_pkg::NCHAN;
    localparam int ChW    = $clog2(NChan);
    localparam int NoiseW = (FRAC_BITS > skf_pkg::REG_W) ? FRAC_BITS : skf_pkg::REG_W;
    localparam int CovW   = (DATA_WIDTH - 1 > FRAC_BITS + 1) ? DATA_WIDTH - 1 : FRAC_BITS + 1;
    localparam int PpW    = ((CovW > NoiseW) ? CovW : NoiseW) + 1;
    localparam int DenW   = PpW + 1;
    localparam int GainW  = FRAC_BITS + 1;
    localparam int DiffW  = FieldW + 1;
    localparam int MulAW  = GainW + 1;
    localparam int MulBW  = (PpW + 1 > DiffW) ? PpW + 1 : DiffW;
    localparam int ProdW  = MulAW + MulBW;
    localparam int SatW   = ProdW + 1;
    localparam int NcW    = ProdW - FRAC_BITS;

    localparam logic [NoiseW-1:0] QReset   = NoiseW'(((1 << FRAC_BITS) * 4 + 500) / 1000);
    localparam logic [NoiseW-1:0] RReset   = NoiseW'(1 << (FRAC_BITS - 1));
    localparam logic [CovW-1:0]   CovReset = CovW'(1 << FRAC_BITS);
    localparam logic [GainW-1:0]  GainOne  = GainW'(1 << FRAC_BITS);

    skf_pkg::skf_state_t state_reg, state_next;

    logic [NoiseW-1:0]       q_reg [NChan];
    logic [NoiseW-1:0]       r_reg [NChan];
    logic [CovW-1:0]         cov_reg [NChan];
    logic signed [FieldW-1:0] prior_reg [NChan];
    logic signed [FieldW-1:0] meas_reg [NChan];
    logic [FieldW-1:0]       est_reg [NChan];
    logic [FieldW-1:0]       est_angle_reg, est_shift_x_reg, est_shift_y_reg;
    logic                    out_valid_reg;
    logic [ChW-1:0]          ch_reg;

    logic [PpW-1:0]          pp_reg, pp_next;
    logic [DenW-1:0]         den_next;
    logic signed [DiffW-1:0] diff_reg, diff_next;
    logic [GainW-1:0]        gain_reg;
    logic signed [ProdW-1:0] prod_reg, mul_p;
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;

    logic signed [ProdW-1:0] prod_shr;
    logic signed [SatW-1:0]  sum_ext, est_smax, est_smin, est_sat;
    logic [FieldW-1:0]       est_next;
    logic [NcW-1:0]          nc_full, cov_max;
    logic [CovW-1:0]         cov_next;

    logic                    div_start;
    logic                    div_done;
    logic [GainW-1:0]        div_quot;
    logic                    out_free;
    logic                    last_ch;

    // Gain divider
    skf_div #(
        .NUM_W (PpW),
        .DEN_W (DenW),
        .Q_W   (GainW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pp_reg),
        .den   (den_next),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Prediction, denominator and innovation
    always_comb
    begin
        pp_next   = PpW'(cov_reg[ch_reg]) + PpW'(q_reg[ch_reg]);
        den_next  = DenW'(pp_reg) + DenW'(r_reg[ch_reg]);
        diff_next = DiffW'(meas_reg[ch_reg]) - DiffW'(prior_reg[ch_reg]);
    end

    // Shared multiplier: gain*innovation, then (1 - gain)*p'
    always_comb
    begin
        if (state_reg == skf_pkg::ST_MUL)
        begin
            mul_a = {1'b0, gain_reg};
            mul_b = MulBW'(diff_reg);
        end
        else
        begin
            mul_a = {1'b0, GainOne - gain_reg};
            mul_b = MulBW'(pp_reg);
        end
        mul_p = mul_a * mul_b;
    end

    // Estimate: floor shift, add prior, saturate to DATA_WIDTH
    always_comb
    begin
        prod_shr = prod_reg >>> FRAC_BITS;
        sum_ext  = SatW'(prod_shr) + SatW'(prior_reg[ch_reg]);
        est_smax = {{(SatW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
        est_smin = ~est_smax;
        if (sum_ext > est_smax)
            est_sat = est_smax;
        else if (sum_ext < est_smin)
            est_sat = est_smin;
        else
            est_sat = sum_ext;
        est_next = est_sat[FieldW-1:0];
    end

    // Covariance update, saturated to the signed maximum
    always_comb
    begin
        nc_full = prod_reg[ProdW-1:FRAC_BITS];
        cov_max = {{(NcW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
        if (nc_full > cov_max)
            cov_next = cov_max[CovW-1:0];
        else
            cov_next = nc_full[CovW-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;
    assign last_ch  = (ch_reg == ChW'(NChan - 1));

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = skf_pkg::ST_PRED;
            end
            skf_pkg::ST_PRED:
                state_next = skf_pkg::ST_DEN;
            skf_pkg::ST_DEN:
            begin
                if (den_next == '0)
                    state_next = skf_pkg::ST_MUL;
                else
                begin
                    div_start  = 1'b1;
                    state_next = skf_pkg::ST_DIV;
                end
            end
            skf_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = skf_pkg::ST_MUL;
            end
            skf_pkg::ST_MUL:
                state_next = skf_pkg::ST_EST;
            skf_pkg::ST_EST:
                state_next = skf_pkg::ST_COV;
            skf_pkg::ST_COV:
                state_next = last_ch ? skf_pkg::ST_DONE : skf_pkg::ST_PRED;
            skf_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = skf_pkg::ST_IDLE;
            end
            default:
                state_next = skf_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= skf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NChan; i++)
            begin
                q_reg[i] <= QReset;
                r_reg[i] <= RReset;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                skf_pkg::REG_Q_ANGLE:   q_reg[0] <= NoiseW'(cfg_data);
                skf_pkg::REG_Q_SHIFT_X: q_reg[1] <= NoiseW'(cfg_data);
                skf_pkg::REG_Q_SHIFT_Y: q_reg[2] <= NoiseW'(cfg_data);
                skf_pkg::REG_R_ANGLE:   r_reg[0] <= NoiseW'(cfg_data);
                skf_pkg::REG_R_SHIFT_X: r_reg[1] <= NoiseW'(cfg_data);
                skf_pkg::REG_R_SHIFT_Y: r_reg[2] <= NoiseW'(cfg_data);
                default: ;
            endcase
        end
    end

    // Covariances, channel counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NChan; i++)
                cov_reg[i] <= CovReset;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == skf_pkg::ST_IDLE)
                ch_reg <= '0;
            if (state_reg == skf_pkg::ST_COV)
            begin
                cov_reg[ch_reg] <= cov_next;
                ch_reg          <= ch_reg + 1'b1;
            end
            if (state_reg == skf_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    prior_reg[0] <= prior_angle;
                    prior_reg[1] <= prior_shift_x;
                    prior_reg[2] <= prior_shift_y;
                    meas_reg[0]  <= meas_angle;
                    meas_reg[1]  <= meas_shift_x;
                    meas_reg[2]  <= meas_shift_y;
                end
            end
            skf_pkg::ST_PRED:
            begin
                pp_reg   <= pp_next;
                diff_reg <= diff_next;
            end
            skf_pkg::ST_DEN:
            begin
                if (den_next == '0)
                    gain_reg <= '0;
            end
            skf_pkg::ST_DIV:
            begin
                if (div_done)
                    gain_reg <= div_quot;
            end
            skf_pkg::ST_MUL:
                prod_reg <= mul_p;
            skf_pkg::ST_EST:
            begin
                est_reg[ch_reg] <= est_next;
                prod_reg        <= mul_p;
            end
            skf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    est_angle_reg   <= est_reg[0];
                    est_shift_x_reg <= est_reg[1];
                    est_shift_y_reg <= est_reg[2];
                end
            end
            default: ;
        endcase
    end

    assign in_ready    = (state_reg == skf_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign est_angle   = est_angle_reg;
    assign est_shift_x = est_shift_x_reg;
    assign est_shift_y = est_shift_y_reg;

endmodule

@@ tb/sv/scalar_kalman_three_channel_tb.sv @@
// Self-checking testbench for the three-channel scalar Kalman filter.
`timescale 1ns / 1ps

module scalar_kalman_three_channel_tb;

    localparam int FRAC = skf_pkg::FRAC_BITS_DEF;
    localparam int DWID = skf_pkg::DATA_WIDTH_DEF;

    typedef logic signed [skf_pkg::FIELD_W-1:0] fix_t;
    typedef fix_t [skf_pkg::NCHAN-1:0] triple_t;
    typedef logic [skf_pkg::REG_W-1:0] noise_t;
    typedef logic [skf_pkg::CFG_IDX_W-1:0] idx_t;

    localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
    localparam fix_t FIX_MIN = 32'sh8000_0000;
    localparam fix_t FIX_ONE = 32'sh0001_0000;

    localparam noise_t NOISE_MAX = '1;
    localparam noise_t NOISE_TOP = 21'd1048576;
    localparam noise_t Q_DEFAULT = skf_pkg::REG_W'(((1 << FRAC) * 4 + 500) / 1000);
    localparam noise_t R_DEFAULT = skf_pkg::REG_W'(1 << (FRAC - 1));

    // indexes with no register behind them
    localparam idx_t REG_NONE_LO = 3'd6;
    localparam idx_t REG_NONE_HI = 3'd7;

    localparam int SETTLE_CYCLES = 3 * (FRAC + 7) + 20;
    localparam int MAX_REPORTS   = 40;
    localparam int FRAMES_PER_PHASE = 250;
    localparam int FRAMES_PER_SETTING = 50;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: filter predictor plus queue of pending estimates
    // ------------------------------------------------------------------
    class kalman_scoreboard;
        localparam longint unsigned ONE_Q = 64'd1 << FRAC;
        localparam longint SAT_MAX = (64'sd1 <<< (DWID - 1)) - 1;
        localparam longint SAT_MIN = -SAT_MAX - 1;

        longint unsigned q_reg [skf_pkg::NCHAN];
        longint unsigned r_reg [skf_pkg::NCHAN];
        longint unsigned cov [skf_pkg::NCHAN];
        triple_t est_queue [$];
        int errors;
        int n_checked;
        int n_zero_den;
        int n_unit_gain;
        string chan_name [skf_pkg::NCHAN] = '{"angle", "shift_x", "shift_y"};

        function new();
            for (int ch = 0; ch < skf_pkg::NCHAN; ch++)
            begin
                q_reg[ch] = Q_DEFAULT;
                r_reg[ch] = R_DEFAULT;
                cov[ch]   = ONE_Q;
            end
            errors      = 0;
            n_checked   = 0;
            n_zero_den  = 0;
            n_unit_gain = 0;
        endfunction

        function void write_noise(idx_t idx, noise_t val);
            case (idx)
                skf_pkg::REG_Q_ANGLE:   q_reg[0] = val;
                skf_pkg::REG_Q_SHIFT_X: q_reg[1] = val;
                skf_pkg::REG_Q_SHIFT_Y: q_reg[2] = val;
                skf_pkg::REG_R_ANGLE:   r_reg[0] = val;
                skf_pkg::REG_R_SHIFT_X: r_reg[1] = val;
                skf_pkg::REG_R_SHIFT_Y: r_reg[2] = val;
                default:       ;
            endcase
        endfunction

        // one channel: gain, blended estimate, covariance update
        function fix_t filter_update(int ch, fix_t prior, fix_t meas);
            longint unsigned pp, den, gain, nc;
            longint signed gain_s, prior_s, meas_s, est;
            prior_s = prior;
            meas_s  = meas;
            pp   = cov[ch] + q_reg[ch];
            den  = pp + r_reg[ch];
            gain = 0;
            if (den != 0)
                gain = (pp << FRAC) / den;
            else
                n_zero_den++;
            if (gain >= ONE_Q)
            begin
                gain = ONE_Q;
                n_unit_gain++;
            end
            gain_s = gain;
            est = prior_s + ((gain_s * (meas_s - prior_s)) >>> FRAC);
            if (est > SAT_MAX)
                est = SAT_MAX;
            if (est < SAT_MIN)
                est = SAT_MIN;
            nc = ((ONE_Q - gain) * pp) >> FRAC;
            if (nc > longint'(SAT_MAX))
                nc = SAT_MAX;
            cov[ch] = nc;
            return est[skf_pkg::FIELD_W-1:0];
        endfunction

        function void add_frame(triple_t prior, triple_t meas);
            triple_t want;
            for (int ch = 0; ch < skf_pkg::NCHAN; ch++)
                want[ch] = filter_update(ch, prior[ch], meas[ch]);
            est_queue.insert(est_queue.size(), want);
        endfunction

        function void check_estimate(triple_t got);
            triple_t want;
            if (est_queue.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: estimate with no frame pending: %0d %0d %0d",
                             $time, got[0], got[1], got[2]);
                return;
            end
            want = est_queue.pop_front();
            n_checked++;
            for (int ch = 0; ch < skf_pkg::NCHAN; ch++)
            begin
                if (got[ch] !== want[ch])
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: est_%s mismatch: expected %0d, actual %0d",
                                 $time, chan_name[ch], want[ch], got[ch]);
                end
            end
        endfunction

        function int pending();
            return est_queue.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic cfg_we;
    idx_t cfg_index;
    noise_t cfg_data;
    logic in_valid;
    logic in_ready;
    fix_t prior_angle, prior_shift_x, prior_shift_y;
    fix_t meas_angle, meas_shift_x, meas_shift_y;
    logic out_valid;
    logic out_ready;
    fix_t est_angle, est_shift_x, est_shift_y;

    kalman_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int n_frames;
    int n_writes;

    scalar_kalman_three_channel u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .prior_angle   (prior_angle),
        .prior_shift_x (prior_shift_x),
        .prior_shift_y (prior_shift_y),
        .meas_angle    (meas_angle),
        .meas_shift_x  (meas_shift_x),
        .meas_shift_y  (meas_shift_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .est_angle     (est_angle),
        .est_shift_x   (est_shift_x),
        .est_shift_y   (est_shift_y)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic triple_t pack3(fix_t a, fix_t x, fix_t y);
        triple_t t;
        t[0] = a;
        t[1] = x;
        t[2] = y;
        return t;
    endfunction

    function automatic fix_t pick_extreme();
        case ($urandom_range(3))
            0:       return FIX_MAX;
            1:       return FIX_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic noise_t pick_noise();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 21'd1;
            2:       return Q_DEFAULT;
            3:       return R_DEFAULT;
            4:       return NOISE_TOP;
            5:       return NOISE_MAX;
            default: return skf_pkg::REG_W'($urandom_range(NOISE_MAX));
        endcase
    endfunction

    // mostly a measurement near the prior, some wide noise and extremes
    function automatic void random_channel(output fix_t prior, output fix_t meas);
        fix_t base, step;
        int sel;
        base = fix_t'($urandom) >>> $urandom_range(16);
        step = fix_t'($urandom) >>> $urandom_range(24, 8);
        sel  = $urandom_range(9);
        if (sel < 6)
        begin
            prior = base;
            meas  = base + step;
        end
        else if (sel < 8)
        begin
            prior = $urandom;
            meas  = $urandom;
        end
        else if (sel < 9)
        begin
            prior = pick_extreme();
            meas  = pick_extreme();
        end
        else
        begin
            prior = base;
            meas  = base;
        end
    endfunction

    // monitor: register writes, input and output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                sb.write_noise(cfg_index, cfg_data);
                n_writes++;
            end
            if (in_valid && in_ready)
            begin
                sb.add_frame(pack3(prior_angle, prior_shift_x, prior_shift_y),
                             pack3(meas_angle, meas_shift_x, meas_shift_y));
                n_frames++;
            end
            if (out_valid && out_ready)
                sb.check_estimate(pack3(est_angle, est_shift_x, est_shift_y));
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_frame(input triple_t prior, input triple_t meas);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        prior_angle   = prior[0];
        prior_shift_x = prior[1];
        prior_shift_y = prior[2];
        meas_angle    = meas[0];
        meas_shift_x  = meas[1];
        meas_shift_y  = meas[2];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and let every pending estimate come out
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input idx_t idx, input noise_t val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic program_noise(input noise_t qa, input noise_t qx, input noise_t qy,
                                 input noise_t ra, input noise_t rx, input noise_t ry);
        write_reg(skf_pkg::REG_Q_ANGLE, qa);
        write_reg(skf_pkg::REG_Q_SHIFT_X, qx);
        write_reg(skf_pkg::REG_Q_SHIFT_Y, qy);
        write_reg(skf_pkg::REG_R_ANGLE, ra);
        write_reg(skf_pkg::REG_R_SHIFT_X, rx);
        write_reg(skf_pkg::REG_R_SHIFT_Y, ry);
    endtask

    task automatic run_random_phase(input int count, input int idle, input int stall);
        triple_t pr, ms;
        fix_t p, m;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
        begin
            // new noise setting every few dozen frames, with the block drained
            if (i % FRAMES_PER_SETTING == 0)
            begin
                drain_and_settle();
                program_noise(pick_noise(), pick_noise(), pick_noise(),
                              pick_noise(), pick_noise(), pick_noise());
                if ($urandom_range(2) == 0)
                    write_reg($urandom_range(1) ? REG_NONE_HI : REG_NONE_LO,
                              skf_pkg::REG_W'($urandom));
            end
            for (int ch = 0; ch < skf_pkg::NCHAN; ch++)
            begin
                random_channel(p, m);
                pr[ch] = p;
                ms[ch] = m;
            end
            send_frame(pr, ms);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        prior_angle   = '0;
        prior_shift_x = '0;
        prior_shift_y = '0;
        meas_angle    = '0;
        meas_shift_x  = '0;
        meas_shift_y  = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        n_frames      = 0;
        n_writes      = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset noise values, field extremes and rounding toward minus infinity
        send_frame(pack3(0, 0, 0), pack3(0, 0, 0));
        send_frame(pack3(0, 0, 0), pack3(FIX_ONE, FIX_ONE, -FIX_ONE));
        send_frame(pack3(FIX_MAX, FIX_MIN, 32'sh5555_5555),
                   pack3(FIX_MIN, FIX_MAX, 32'shAAAA_AAAA));
        send_frame(pack3(FIX_MAX, FIX_MIN, -1), pack3(FIX_MAX, FIX_MIN, -1));
        send_frame(pack3(1, -1, FIX_MIN), pack3(-1, 1, 0));
        send_frame(pack3(-3, 5, 32'sh0001_8000), pack3(0, -7, 32'sh7FFF_0000));

        // largest and smallest noise values
        drain_and_settle();
        program_noise(NOISE_MAX, NOISE_TOP, '0, NOISE_MAX, NOISE_TOP, 21'd1);
        send_frame(pack3(0, FIX_MAX, FIX_MIN), pack3(FIX_MAX, FIX_MIN, FIX_MAX));
        send_frame(pack3(FIX_ONE, -FIX_ONE, 7), pack3(-FIX_ONE, FIX_ONE, -7));
        send_frame(pack3(FIX_MIN, 0, FIX_MAX), pack3(FIX_MAX, 0, FIX_MIN));
        send_frame(pack3(-1, -1, -1), pack3(1, 1, 1));

        // zero measurement noise: estimate follows the measurement
        drain_and_settle();
        program_noise(Q_DEFAULT, Q_DEFAULT, Q_DEFAULT, '0, '0, '0);
        send_frame(pack3(0, FIX_MAX, FIX_MIN), pack3(FIX_ONE, FIX_MIN, FIX_MAX));
        send_frame(pack3(123, -456, 789), pack3(-123, 456, -789));
        send_frame(pack3(FIX_MAX, FIX_MIN, 0), pack3(0, 0, 0));

        // zero process and measurement noise with zero covariance: zero denominator
        drain_and_settle();
        program_noise('0, '0, '0, '0, '0, '0);
        send_frame(pack3(FIX_ONE, FIX_MIN, FIX_MAX), pack3(0, FIX_MAX, FIX_MIN));
        send_frame(pack3(-5, 5, 0), pack3(5, -5, FIX_ONE));

        // writes to unused indexes change nothing
        drain_and_settle();
        write_reg(REG_NONE_LO, NOISE_MAX);
        write_reg(REG_NONE_HI, NOISE_MAX);
        send_frame(pack3(42, -42, FIX_MIN), pack3(-42, 42, FIX_MAX));

        drain_and_settle();
        program_noise(Q_DEFAULT, Q_DEFAULT, Q_DEFAULT, R_DEFAULT, R_DEFAULT, R_DEFAULT);

        // random frames under each back-pressure profile
        run_random_phase(FRAMES_PER_PHASE, 0, 0);
        run_random_phase(FRAMES_PER_PHASE, 76, 0);
        run_random_phase(FRAMES_PER_PHASE, 0, 76);
        run_random_phase(FRAMES_PER_PHASE, 22, 22);

        drain_and_settle();

        $display("Covered %0d frames, %0d estimates checked, %0d register writes,",
                 n_frames, sb.n_checked, n_writes);
        $display("%0d zero-denominator and %0d unit-gain channel updates, %0d errors",
                 sb.n_zero_den, sb.n_unit_gain, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
